// ----- design/cavlc_coeff_token_encoder_defines.svh -----
// ----------------------------------------------------------------------------
// CAVLC coeff_token encoder assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef CAVLC_COEFF_TOKEN_ENCODER_DEFINES_SVH
`define CAVLC_COEFF_TOKEN_ENCODER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CTE_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("coeff_token encoder check failed");

// The consequent must hold in the cycle after the antecedent.
`define CTE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("coeff_token encoder check failed");

`endif

// ----- design/cte_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CAVLC coeff_token encoder package
// Table entry type, table selector codes and the coeff_token code tables.
// ----------------------------------------------------------------------------
package cte_pkg;

    // One code table entry: length in bits and right-aligned codeword.
    typedef struct packed {
        logic [4:0] len;
        logic [3:0] code;
    } entry_t;

    // Which code table serves the current nC context.
    typedef enum logic [2:0] {
        TAB_NC0,
        TAB_NC2,
        TAB_NC4,
        TAB_FLC,
        TAB_DC420,
        TAB_DC422
    } tab_sel_t;

    localparam int NUM_T1       = 4;
    localparam int NUM_TC       = 17;
    localparam int NUM_TC_DC420 = 5;
    localparam int NUM_TC_DC422 = 9;

    localparam logic [4:0] MAX_TC       = 5'd16;
    localparam logic [4:0] MAX_TC_DC420 = 5'd4;
    localparam logic [4:0] MAX_TC_DC422 = 5'd8;
    localparam logic [4:0] FLC_LEN      = 5'd6;
    localparam logic [5:0] FLC_ZERO     = 6'd3;

    function automatic entry_t ent(input int l, input int c);
        entry_t e;
        e.len  = l[4:0];
        e.code = c[3:0];
        return e;
    endfunction

    // Rows are indexed by trailing ones, columns by total coefficients.
    localparam entry_t TAB_NC0_ROM [NUM_T1][NUM_TC] = '{
        '{ent(1,1),ent(6,5),ent(8,7),ent(9,7),ent(10,7),ent(11,7),ent(13,15),ent(13,11),
          ent(13,8),ent(14,15),ent(14,11),ent(15,15),ent(15,11),ent(16,15),ent(16,11),
          ent(16,7),ent(16,4)},
        '{ent(0,0),ent(2,1),ent(6,4),ent(8,6),ent(9,6),ent(10,6),ent(11,6),ent(13,14),
          ent(13,10),ent(14,14),ent(14,10),ent(15,14),ent(15,10),ent(15,1),ent(16,14),
          ent(16,10),ent(16,6)},
        '{ent(0,0),ent(0,0),ent(3,1),ent(7,5),ent(8,5),ent(9,5),ent(10,5),ent(11,5),
          ent(13,13),ent(13,9),ent(14,13),ent(14,9),ent(15,13),ent(15,9),ent(16,13),
          ent(16,9),ent(16,5)},
        '{ent(0,0),ent(0,0),ent(0,0),ent(5,3),ent(6,3),ent(7,4),ent(8,4),ent(9,4),
          ent(10,4),ent(11,4),ent(13,12),ent(14,12),ent(14,8),ent(15,12),ent(15,8),
          ent(16,12),ent(16,8)}
    };

    localparam entry_t TAB_NC2_ROM [NUM_T1][NUM_TC] = '{
        '{ent(2,3),ent(6,11),ent(6,7),ent(7,7),ent(8,7),ent(8,4),ent(9,7),ent(11,15),
          ent(11,11),ent(12,15),ent(12,11),ent(12,8),ent(13,15),ent(13,11),ent(13,7),
          ent(14,9),ent(14,7)},
        '{ent(0,0),ent(2,2),ent(5,7),ent(6,10),ent(6,6),ent(7,6),ent(8,6),ent(9,6),
          ent(11,14),ent(11,10),ent(12,14),ent(12,10),ent(13,14),ent(13,10),ent(14,11),
          ent(14,8),ent(14,6)},
        '{ent(0,0),ent(0,0),ent(3,3),ent(6,9),ent(6,5),ent(7,5),ent(8,5),ent(9,5),
          ent(11,13),ent(11,9),ent(12,13),ent(12,9),ent(13,13),ent(13,9),ent(13,6),
          ent(14,10),ent(14,5)},
        '{ent(0,0),ent(0,0),ent(0,0),ent(4,5),ent(4,4),ent(5,6),ent(6,8),ent(6,4),
          ent(7,4),ent(9,4),ent(11,12),ent(11,8),ent(12,12),ent(13,12),ent(13,8),
          ent(13,1),ent(14,4)}
    };

    localparam entry_t TAB_NC4_ROM [NUM_T1][NUM_TC] = '{
        '{ent(4,15),ent(6,15),ent(6,11),ent(6,8),ent(7,15),ent(7,11),ent(7,9),ent(7,8),
          ent(8,15),ent(8,11),ent(9,15),ent(9,11),ent(9,8),ent(10,13),ent(10,9),
          ent(10,5),ent(10,1)},
        '{ent(0,0),ent(4,14),ent(5,15),ent(5,12),ent(5,10),ent(5,8),ent(6,14),ent(6,10),
          ent(7,14),ent(8,14),ent(8,10),ent(9,14),ent(9,10),ent(9,7),ent(10,12),
          ent(10,8),ent(10,4)},
        '{ent(0,0),ent(0,0),ent(4,13),ent(5,14),ent(5,11),ent(5,9),ent(6,13),ent(6,9),
          ent(7,13),ent(7,10),ent(8,13),ent(8,9),ent(9,13),ent(9,9),ent(10,11),
          ent(10,7),ent(10,3)},
        '{ent(0,0),ent(0,0),ent(0,0),ent(4,12),ent(4,11),ent(4,10),ent(4,9),ent(4,8),
          ent(5,13),ent(6,12),ent(7,12),ent(8,12),ent(8,8),ent(9,12),ent(10,10),
          ent(10,6),ent(10,2)}
    };

    localparam entry_t TAB_DC420_ROM [NUM_T1][NUM_TC_DC420] = '{
        '{ent(2,1),ent(6,7),ent(6,4),ent(6,3),ent(6,2)},
        '{ent(0,0),ent(1,1),ent(6,6),ent(7,3),ent(8,3)},
        '{ent(0,0),ent(0,0),ent(3,1),ent(7,2),ent(8,2)},
        '{ent(0,0),ent(0,0),ent(0,0),ent(6,5),ent(7,0)}
    };

    localparam entry_t TAB_DC422_ROM [NUM_T1][NUM_TC_DC422] = '{
        '{ent(1,1),ent(7,15),ent(7,14),ent(9,7),ent(9,6),ent(10,7),ent(11,7),ent(12,7),
          ent(13,7)},
        '{ent(0,0),ent(2,1),ent(7,13),ent(7,12),ent(9,5),ent(10,6),ent(11,6),ent(12,6),
          ent(12,5)},
        '{ent(0,0),ent(0,0),ent(3,1),ent(7,11),ent(7,10),ent(9,4),ent(10,5),ent(11,5),
          ent(12,4)},
        '{ent(0,0),ent(0,0),ent(0,0),ent(5,1),ent(6,1),ent(7,9),ent(7,8),ent(10,4),
          ent(11,4)}
    };

endpackage

// ----- design/cavlc_coeff_token_encoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CAVLC coeff_token encoder
// Maps (total_coeffs, trailing_ones, nC) to the H.264 coeff_token codeword.
// ----------------------------------------------------------------------------
// Usage:
// A transaction is issued by raising start with total_coeffs, trailing_ones
// and neighbour_count valid; it is accepted at the rising edge where start is
// high and busy is low. busy is never raised, so one transaction can be
// issued in every cycle.
// Each accepted transaction yields exactly one result on code_length,
// code_word and invalid, marked by done for one cycle. The result passes
// through the input register, then the table lookup settles into the
// result register. Throughput is one transaction per cycle; the depth is
// set by the input and result registers around the single lookup stage.
// Pairs with no codeword (more trailing ones than coefficients, or too many
// coefficients for the selected table) give invalid = 1 with zero length and
// zero codeword.
// Reset clears the valid flags of both stages, so no result is produced for
// anything in flight. The receiver cannot stall: done is a plain strobe.
// ----------------------------------------------------------------------------
`include "cavlc_coeff_token_encoder_defines.svh"

module cavlc_coeff_token_encoder
    import cte_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [4:0]        total_coeffs,
    input  logic [1:0]        trailing_ones,
    input  logic signed [5:0] neighbour_count,
    output logic              done,
    output logic [4:0]        code_length,
    output logic [5:0]        code_word,
    output logic              invalid
);

    // Input stage registers.
    logic              in_vld_reg;
    logic [4:0]        tc_reg;
    logic [1:0]        t1_reg;
    logic signed [5:0] nc_reg;

    // Result stage registers.
    logic       done_reg;
    logic [4:0] len_reg;
    logic [5:0] code_reg;
    logic       bad_reg;

    logic       len_bad;
    logic       bad_next;
    logic [4:0] len_next;
    logic [5:0] code_next;
    tab_sel_t   tab_sel;
    entry_t     rom_entry;
    logic [4:0] tc_minus1;

    // The lookup has no state, so the block never holds off a transaction.
    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            tc_reg <= total_coeffs;
            t1_reg <= trailing_ones;
            nc_reg <= neighbour_count;
        end
    end

    // Table selection from the nC context. Negative values other than the
    // two chroma DC codes fall to the fixed-length code, as large nC does.
    always_comb
    begin
        if (nc_reg == -6'sd1)
        begin
            tab_sel = TAB_DC420;
        end
        else if (nc_reg == -6'sd2)
        begin
            tab_sel = TAB_DC422;
        end
        else if (nc_reg >= 6'sd0 && nc_reg < 6'sd2)
        begin
            tab_sel = TAB_NC0;
        end
        else if (nc_reg >= 6'sd2 && nc_reg < 6'sd4)
        begin
            tab_sel = TAB_NC2;
        end
        else if (nc_reg >= 6'sd4 && nc_reg < 6'sd8)
        begin
            tab_sel = TAB_NC4;
        end
        else
        begin
            tab_sel = TAB_FLC;
        end
    end

    assign tc_minus1 = tc_reg - 5'd1;

    // Lookup and range checks for the selected table.
    always_comb
    begin
        rom_entry = '0;
        len_bad   = ({3'b000, t1_reg} > tc_reg) || (tc_reg > MAX_TC);
        len_next  = 5'd0;
        code_next = 6'd0;
        unique case (tab_sel)
            TAB_NC0:
            begin
                if (!len_bad)
                begin
                    rom_entry = TAB_NC0_ROM[t1_reg][tc_reg];
                end
            end
            TAB_NC2:
            begin
                if (!len_bad)
                begin
                    rom_entry = TAB_NC2_ROM[t1_reg][tc_reg];
                end
            end
            TAB_NC4:
            begin
                if (!len_bad)
                begin
                    rom_entry = TAB_NC4_ROM[t1_reg][tc_reg];
                end
            end
            TAB_DC420:
            begin
                if (tc_reg > MAX_TC_DC420)
                begin
                    len_bad = 1'b1;
                end
                else if (!len_bad)
                begin
                    rom_entry = TAB_DC420_ROM[t1_reg][tc_reg[2:0]];
                end
            end
            TAB_DC422:
            begin
                if (tc_reg > MAX_TC_DC422)
                begin
                    len_bad = 1'b1;
                end
                else if (!len_bad)
                begin
                    rom_entry = TAB_DC422_ROM[t1_reg][tc_reg[3:0]];
                end
            end
            TAB_FLC:
            begin
                rom_entry = '0;
            end
            default:
            begin
                rom_entry = '0;
            end
        endcase

        if (tab_sel == TAB_FLC)
        begin
            // Six-bit fixed-length code: all-zero count pair maps to 3.
            len_next  = FLC_LEN;
            code_next = (tc_reg == 5'd0) ? FLC_ZERO : {tc_minus1[3:0], t1_reg};
        end
        else
        begin
            len_next  = rom_entry.len;
            code_next = {2'b00, rom_entry.code};
        end

        bad_next = len_bad;
        if (len_bad)
        begin
            len_next  = 5'd0;
            code_next = 6'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= in_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_vld_reg)
        begin
            len_reg  <= len_next;
            code_reg <= code_next;
            bad_reg  <= bad_next;
        end
    end

    assign done        = done_reg;
    assign code_length = len_reg;
    assign code_word   = code_reg;
    assign invalid     = bad_reg;

    // Every accepted transaction raises the input valid flag and then done.
    `CTE_ASSERT_NEXT(a_result_follows, start && !busy, in_vld_reg)
    `CTE_ASSERT_NEXT(a_done_follows, in_vld_reg, done)
    // An invalid result carries no codeword bits.
    `CTE_ASSERT_SAME(a_invalid_zero, done && invalid, code_length == 5'd0 && code_word == 6'd0)
    // A valid result always has a nonzero length.
    `CTE_ASSERT_SAME(a_valid_nonzero, done && !invalid, code_length != 5'd0)
    // More trailing ones than coefficients never yields a codeword.
    `CTE_ASSERT_NEXT(a_t1_over_tc, in_vld_reg && ({3'b000, t1_reg} > tc_reg), invalid)

endmodule

// ----- tb/sv/tb_cavlc_coeff_token_encoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CAVLC coeff_token encoder testbench
// Self-checking bench for cavlc_coeff_token_encoder. A queue of requests is
// filled up front: a short directed set covering every code table, the table
// edges and every class of illegal count pair, then several hundred random
// requests that are mostly well formed, with raw random noise mixed in. A
// clocked driver issues them in random bursts, and a clocked monitor predicts
// each accepted transaction with a local table model and checks every result
// field against it in order.
// ----------------------------------------------------------------------------
module tb_cavlc_coeff_token_encoder;
    import cte_pkg::*;

    // Give up well past the slowest legal run (about 575 transactions, each
    // with at most a short gap, plus a few drain pauses).
    localparam int CYCLE_LIMIT  = 60000;
    localparam int RANDOM_ITEMS = 550;
    // The result register sits behind the input register; allow some slack.
    localparam int TAIL_CYCLES  = 6;

    // One coeff_token result as the block reports it.
    typedef struct packed {
        logic [4:0] len;
        logic [5:0] word;
        logic       bad;
    } coeff_token_t;

    // One block to be encoded. When drain_first is set, the driver holds this
    // transaction back until every earlier result has come out.
    typedef struct {
        logic [4:0]        tc;
        logic [1:0]        t1;
        logic signed [5:0] nc;
        bit                drain_first;
    } token_req_t;

    // Code tables as {length, codeword}; rows are trailing ones, columns are
    // total coefficients. Cells with more trailing ones than coefficients are
    // never read, since such pairs are rejected first.
    localparam int NC0_CODES [4][17][2] = '{
        '{'{1,1},'{6,5},'{8,7},'{9,7},'{10,7},'{11,7},'{13,15},'{13,11},'{13,8},
          '{14,15},'{14,11},'{15,15},'{15,11},'{16,15},'{16,11},'{16,7},'{16,4}},
        '{'{0,0},'{2,1},'{6,4},'{8,6},'{9,6},'{10,6},'{11,6},'{13,14},'{13,10},
          '{14,14},'{14,10},'{15,14},'{15,10},'{15,1},'{16,14},'{16,10},'{16,6}},
        '{'{0,0},'{0,0},'{3,1},'{7,5},'{8,5},'{9,5},'{10,5},'{11,5},'{13,13},
          '{13,9},'{14,13},'{14,9},'{15,13},'{15,9},'{16,13},'{16,9},'{16,5}},
        '{'{0,0},'{0,0},'{0,0},'{5,3},'{6,3},'{7,4},'{8,4},'{9,4},'{10,4},
          '{11,4},'{13,12},'{14,12},'{14,8},'{15,12},'{15,8},'{16,12},'{16,8}}
    };

    localparam int NC2_CODES [4][17][2] = '{
        '{'{2,3},'{6,11},'{6,7},'{7,7},'{8,7},'{8,4},'{9,7},'{11,15},'{11,11},
          '{12,15},'{12,11},'{12,8},'{13,15},'{13,11},'{13,7},'{14,9},'{14,7}},
        '{'{0,0},'{2,2},'{5,7},'{6,10},'{6,6},'{7,6},'{8,6},'{9,6},'{11,14},
          '{11,10},'{12,14},'{12,10},'{13,14},'{13,10},'{14,11},'{14,8},'{14,6}},
        '{'{0,0},'{0,0},'{3,3},'{6,9},'{6,5},'{7,5},'{8,5},'{9,5},'{11,13},
          '{11,9},'{12,13},'{12,9},'{13,13},'{13,9},'{13,6},'{14,10},'{14,5}},
        '{'{0,0},'{0,0},'{0,0},'{4,5},'{4,4},'{5,6},'{6,8},'{6,4},'{7,4},
          '{9,4},'{11,12},'{11,8},'{12,12},'{13,12},'{13,8},'{13,1},'{14,4}}
    };

    localparam int NC4_CODES [4][17][2] = '{
        '{'{4,15},'{6,15},'{6,11},'{6,8},'{7,15},'{7,11},'{7,9},'{7,8},'{8,15},
          '{8,11},'{9,15},'{9,11},'{9,8},'{10,13},'{10,9},'{10,5},'{10,1}},
        '{'{0,0},'{4,14},'{5,15},'{5,12},'{5,10},'{5,8},'{6,14},'{6,10},'{7,14},
          '{8,14},'{8,10},'{9,14},'{9,10},'{9,7},'{10,12},'{10,8},'{10,4}},
        '{'{0,0},'{0,0},'{4,13},'{5,14},'{5,11},'{5,9},'{6,13},'{6,9},'{7,13},
          '{7,10},'{8,13},'{8,9},'{9,13},'{9,9},'{10,11},'{10,7},'{10,3}},
        '{'{0,0},'{0,0},'{0,0},'{4,12},'{4,11},'{4,10},'{4,9},'{4,8},'{5,13},
          '{6,12},'{7,12},'{8,12},'{8,8},'{9,12},'{10,10},'{10,6},'{10,2}}
    };

    localparam int DC420_CODES [4][5][2] = '{
        '{'{2,1},'{6,7},'{6,4},'{6,3},'{6,2}},
        '{'{0,0},'{1,1},'{6,6},'{7,3},'{8,3}},
        '{'{0,0},'{0,0},'{3,1},'{7,2},'{8,2}},
        '{'{0,0},'{0,0},'{0,0},'{6,5},'{7,0}}
    };

    localparam int DC422_CODES [4][9][2] = '{
        '{'{1,1},'{7,15},'{7,14},'{9,7},'{9,6},'{10,7},'{11,7},'{12,7},'{13,7}},
        '{'{0,0},'{2,1},'{7,13},'{7,12},'{9,5},'{10,6},'{11,6},'{12,6},'{12,5}},
        '{'{0,0},'{0,0},'{3,1},'{7,11},'{7,10},'{9,4},'{10,5},'{11,5},'{12,4}},
        '{'{0,0},'{0,0},'{0,0},'{5,1},'{6,1},'{7,9},'{7,8},'{10,4},'{11,4}}
    };

    logic              clk             = 1'b0;
    logic              rst_n           = 1'b0;
    logic              start           = 1'b0;
    logic              busy;
    logic [4:0]        total_coeffs    = '0;
    logic [1:0]        trailing_ones   = '0;
    logic signed [5:0] neighbour_count = '0;
    logic              done;
    logic [4:0]        code_length;
    logic [5:0]        code_word;
    logic              invalid;

    token_req_t   token_reqs[$];
    coeff_token_t expected_tokens[$];
    int           error_count = 0;
    int           cycle_count = 0;
    // Set by the monitor at each rising edge when the block took a transaction.
    bit           took_item   = 1'b0;
    int           burst_left  = 0;
    int           gap_left    = 0;

    cavlc_coeff_token_encoder dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .total_coeffs    (total_coeffs),
        .trailing_ones   (trailing_ones),
        .neighbour_count (neighbour_count),
        .done            (done),
        .code_length     (code_length),
        .code_word       (code_word),
        .invalid         (invalid)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Works out the coeff_token for one block. The nC context picks the table;
    // any nC outside the chroma DC values and 0..7 falls to the 6-bit fixed
    // code, including values below -2 and above 16. Illegal count pairs give
    // the invalid flag with zero length and zero codeword.
    function automatic coeff_token_t predict_coeff_token(input logic [4:0] tc,
                                                         input logic [1:0] t1,
                                                         input logic signed [5:0] nc);
        coeff_token_t res;
        tab_sel_t     sel;
        res = '0;
        if (nc == -1)
            sel = TAB_DC420;
        else if (nc == -2)
            sel = TAB_DC422;
        else if (nc >= 0 && nc < 2)
            sel = TAB_NC0;
        else if (nc >= 2 && nc < 4)
            sel = TAB_NC2;
        else if (nc >= 4 && nc < 8)
            sel = TAB_NC4;
        else
            sel = TAB_FLC;

        if (t1 > tc || tc > 16)
            res.bad = 1'b1;
        else if (sel == TAB_DC420 && tc > 4)
            res.bad = 1'b1;
        else if (sel == TAB_DC422 && tc > 8)
            res.bad = 1'b1;
        else
        begin
            case (sel)
                TAB_NC0:
                begin
                    res.len  = 5'(NC0_CODES[t1][tc][0]);
                    res.word = 6'(NC0_CODES[t1][tc][1]);
                end
                TAB_NC2:
                begin
                    res.len  = 5'(NC2_CODES[t1][tc][0]);
                    res.word = 6'(NC2_CODES[t1][tc][1]);
                end
                TAB_NC4:
                begin
                    res.len  = 5'(NC4_CODES[t1][tc][0]);
                    res.word = 6'(NC4_CODES[t1][tc][1]);
                end
                TAB_DC420:
                begin
                    res.len  = 5'(DC420_CODES[t1][tc[2:0]][0]);
                    res.word = 6'(DC420_CODES[t1][tc[2:0]][1]);
                end
                TAB_DC422:
                begin
                    res.len  = 5'(DC422_CODES[t1][tc[3:0]][0]);
                    res.word = 6'(DC422_CODES[t1][tc[3:0]][1]);
                end
                default:
                begin
                    // Fixed-length code: an empty block has its own codeword,
                    // otherwise it is (total - 1) over trailing ones.
                    res.len = 5'd6;
                    if (tc == 0)
                        res.word = 6'd3;
                    else
                        res.word = {tc[3:0] - 4'd1, t1};
                end
            endcase
        end
        return res;
    endfunction

    task automatic add_req(input logic [4:0] tc, input logic [1:0] t1,
                           input logic signed [5:0] nc, input bit drain_first);
        token_req_t req;
        req.tc          = tc;
        req.t1          = t1;
        req.nc          = nc;
        req.drain_first = drain_first;
        token_reqs.push_back(req);
    endtask

    // Driver. Inputs move on the falling edge only. A new transaction is put
    // up once the previous one has been taken (or none was pending), and the
    // sender alternates between bursts of random length and random gaps. The
    // start line gets exactly one nonblocking write per falling edge, so a
    // back-to-back burst keeps it high without a glitch.
    always @(negedge clk)
    begin
        token_req_t req;
        if (!rst_n)
            start <= 1'b0;
        else if (!start || took_item)
        begin
            if (gap_left > 0)
            begin
                gap_left = gap_left - 1;
                start <= 1'b0;
            end
            else if (token_reqs.size() == 0)
                start <= 1'b0;
            else if (token_reqs[0].drain_first && expected_tokens.size() != 0)
                start <= 1'b0;
            else
            begin
                req = token_reqs.pop_front();
                total_coeffs    <= req.tc;
                trailing_ones   <= req.t1;
                neighbour_count <= req.nc;
                start           <= 1'b1;
                if (burst_left > 0)
                    burst_left = burst_left - 1;
                if (burst_left == 0)
                begin
                    // Long bursts give stretches with no idle cycles at all;
                    // a gap of zero simply joins two bursts together.
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
        end
    end

    // Monitor. Everything is sampled on the rising edge, after the falling edge on
    // which the driver last touched the inputs. Results are checked before the
    // transaction taken at this edge is predicted, so the order of the
    // expectation queue always follows the order of acceptance.
    always @(posedge clk)
    begin
        coeff_token_t want;
        took_item = 1'b0;
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_tokens.size() == 0)
                begin
                    $error("result with no transaction outstanding: len=%0d word=%0d inv=%0b",
                           code_length, code_word, invalid);
                    error_count++;
                end
                else
                begin
                    want = expected_tokens.pop_front();
                    if (code_length !== want.len)
                    begin
                        $error("code_length: expected %0d, actual %0d", want.len, code_length);
                        error_count++;
                    end
                    if (code_word !== want.word)
                    begin
                        $error("code_word: expected %0d, actual %0d", want.word, code_word);
                        error_count++;
                    end
                    if (invalid !== want.bad)
                    begin
                        $error("invalid: expected %0b, actual %0b", want.bad, invalid);
                        error_count++;
                    end
                end
            end
            if (start && !busy)
            begin
                took_item = 1'b1;
                expected_tokens.push_back(predict_coeff_token(total_coeffs, trailing_ones,
                                                              neighbour_count));
            end
        end
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_cavlc_coeff_token_encoder: done, errors");
            $finish;
        end
    end

    initial
    begin
        int                kind;
        int                sel;
        int                max_tc;
        logic [4:0]        tc;
        logic [1:0]        t1;
        logic signed [5:0] nc;

        // Directed set. Empty blocks in every table.
        add_req(5'd0, 2'd0, 6'sd0, 1'b0);
        add_req(5'd0, 2'd0, 6'sd2, 1'b0);
        add_req(5'd0, 2'd0, 6'sd4, 1'b0);
        add_req(5'd0, 2'd0, 6'sd8, 1'b0);
        add_req(5'd0, 2'd0, -6'sd1, 1'b0);
        add_req(5'd0, 2'd0, -6'sd2, 1'b0);
        // Largest legal totals, and the edges of each nC range.
        add_req(5'd16, 2'd3, 6'sd0, 1'b0);
        add_req(5'd16, 2'd1, 6'sd3, 1'b0);
        add_req(5'd16, 2'd0, 6'sd7, 1'b0);
        add_req(5'd16, 2'd3, 6'sd16, 1'b0);
        add_req(5'd2, 2'd2, 6'sd1, 1'b0);
        add_req(5'd4, 2'd3, -6'sd1, 1'b0);
        add_req(5'd8, 2'd3, -6'sd2, 1'b0);
        // More trailing ones than coefficients.
        add_req(5'd0, 2'd3, 6'sd0, 1'b0);
        add_req(5'd1, 2'd2, -6'sd1, 1'b0);
        add_req(5'd2, 2'd3, 6'sd9, 1'b0);
        // Too many coefficients for the chroma DC tables, or for any table.
        add_req(5'd5, 2'd0, -6'sd1, 1'b0);
        add_req(5'd9, 2'd1, -6'sd2, 1'b0);
        add_req(5'd31, 2'd0, 6'sd0, 1'b0);
        add_req(5'd17, 2'd3, 6'sd12, 1'b0);
        // nC below -2 and above 16 both use the fixed-length code.
        add_req(5'd3, 2'd2, -6'sd32, 1'b0);
        add_req(5'd0, 2'd0, -6'sd3, 1'b0);
        add_req(5'd1, 2'd1, 6'sd17, 1'b0);
        add_req(5'd7, 2'd2, 6'sd31, 1'b0);

        // Random part. Most transactions are legal pairs aimed at one table;
        // the rest are raw bit patterns, which reach nC outside -2..16, totals
        // above 16 and every input bit in both states. A few transactions wait
        // for the pipeline to run dry first.
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 15)
            begin
                tc = 5'($urandom);
                t1 = 2'($urandom);
                nc = 6'($urandom);
            end
            else
            begin
                sel    = $urandom_range(0, 5);
                max_tc = 16;
                case (sel)
                    0: nc = 6'($urandom_range(0, 1));
                    1: nc = 6'($urandom_range(2, 3));
                    2: nc = 6'($urandom_range(4, 7));
                    3: nc = 6'($urandom_range(8, 16));
                    4:
                    begin
                        nc     = -6'sd1;
                        max_tc = 4;
                    end
                    default:
                    begin
                        nc     = -6'sd2;
                        max_tc = 8;
                    end
                endcase
                tc = 5'($urandom_range(0, max_tc));
                t1 = 2'($urandom_range(0, (tc < 3) ? int'(tc) : 3));
            end
            add_req(tc, t1, nc, i == 0 || i == 200 || i == 400);
        end

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Let every queued transaction go out and every result come back.
        while (token_reqs.size() != 0 || start || expected_tokens.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("tb_cavlc_coeff_token_encoder: done, clean");
        else
            $display("tb_cavlc_coeff_token_encoder: done, errors");
        $finish;
    end

endmodule
